// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the image header size parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define IHSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define IHSP_ASSERT_NEVER(label, cond, msg) \
  `IHSP_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/ihsp_pkg.sv =====
// Types and constants for the image header size parser.
package ihsp_pkg;

  // Number of leading file bytes kept for signature and header checks.
  localparam int HEADER_BYTES = 24;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

  typedef logic [1:0] format_t;

  localparam format_t FMT_NONE = 2'd0;
  localparam format_t FMT_JPEG = 2'd1;
  localparam format_t FMT_GIF  = 2'd2;
  localparam format_t FMT_PNG  = 2'd3;

  // JPEG marker bytes.
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] SOI_CODE    = 8'hD8;
  localparam logic [7:0] APP0_CODE   = 8'hE0;

  // PNG signature bytes that are not plain letters.
  localparam logic [7:0] PNG_LEAD = 8'h89;
  localparam logic [7:0] PNG_CR   = 8'h0D;
  localparam logic [7:0] PNG_LF   = 8'h0A;
  localparam logic [7:0] PNG_EOF  = 8'h1A;

  // True for a start-of-frame marker code that carries the frame size.
  function automatic logic is_sof(input logic [7:0] code);
    logic low_group;
    logic high_group;
    low_group  = (code >= 8'hC0) && (code <= 8'hC3);
    high_group = (code >= 8'hC9) && (code <= 8'hCB);
    return low_group || high_group;
  endfunction

endpackage

// ===== rtl/core/ihsp_in_if.sv =====
// Byte stream channel into the image header size parser.
interface ihsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ihsp_out_if.sv =====
// Result channel out of the image header size parser.
interface ihsp_out_if
  import ihsp_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        found;
  format_t     image_format;
  logic [31:0] image_width;
  logic [31:0] image_height;

  modport source (output valid, output found, output image_format, output image_width,
                  output image_height, input ready);
  modport sink (input valid, input found, input image_format, input image_width,
                input image_height, output ready);
endinterface

// ===== rtl/core/image_header_size_parser.sv =====
// Image header size parser top level: JPEG, GIF and PNG dimension reader.
// Throughput: one byte beat per cycle; the byte register only holds when a last beat
// waits for a full result register.
// Result path: a last beat's result is registered in the result register when the beat leaves the byte register.
// Reset: synchronous rst clears the pipeline valids and the walk state; after each
// last beat the walk state returns to its reset values for the next file.
`include "assert_macros.svh"

module image_header_size_parser
  import ihsp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  ihsp_in_if.sink      stream,
  ihsp_out_if.source   result
);

  localparam logic [2:0] PH_MARK  = 3'd0;
  localparam logic [2:0] PH_CODE  = 3'd1;
  localparam logic [2:0] PH_LENH  = 3'd2;
  localparam logic [2:0] PH_LENL  = 3'd3;
  localparam logic [2:0] PH_FRAME = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  localparam int                     SUM_W    = OFFSET_BITS + 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] SEG_INIT = OFFSET_BITS'(2);

  // Input byte register.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;
  logic       advance;

  // Walk and header state.
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] segment_start;
  logic [7:0]             segment_length_high;
  logic [2:0]             walk_phase;
  logic                   frame_found;
  logic                   walk_failed;
  logic [15:0]            frame_height;
  logic [15:0]            frame_width;
  logic [7:0]             header_store [HEADER_BYTES];

  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [OFFSET_BITS-1:0] segment_start_next;
  logic [7:0]             segment_length_high_next;
  logic [2:0]             walk_phase_next;
  logic                   frame_found_next;
  logic                   walk_failed_next;
  logic [15:0]            frame_height_next;
  logic [15:0]            frame_width_next;

  logic             saturated;
  logic             hdr_write;
  logic [SUM_W-1:0] seg_sum;
  logic [SUM_W-1:0] seg_dist;
  logic [15:0]      seg_length;
  logic [7:0]       hv [HEADER_BYTES];

  logic        res_found;
  format_t     res_format;
  logic [31:0] res_width;
  logic [31:0] res_height;
  logic        long_enough;
  logic        frame_fits;
  logic        soi_ok;
  logic        jfif_ok;
  logic        gif_ok;
  logic        png_ok;

  // The byte register waits only when a last beat needs a free result register.
  assign advance      = stage_valid && (!stage_last || !result.valid || result.ready);
  assign stream.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stream.ready) begin
      stage_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      stage_byte <= stream.data_byte;
      stage_last <= stream.last_byte;
    end
  end

  // Offset bookkeeping and the segment distance used by the walk.
  assign saturated  = (byte_offset == OFF_MAX);
  assign hdr_write  = !saturated && (byte_offset < OFFSET_BITS'(HEADER_BYTES));
  assign seg_length = {segment_length_high, stage_byte};
  assign seg_sum    = {1'b0, segment_start} + SUM_W'(seg_length) + SUM_W'(2);
  assign seg_dist   = {1'b0, byte_offset} - {1'b0, segment_start};
  assign byte_offset_next = saturated ? byte_offset : byte_offset + OFFSET_BITS'(1);

  // JPEG segment walk for the current byte.
  always_comb begin
    segment_start_next       = segment_start;
    segment_length_high_next = segment_length_high;
    walk_phase_next          = walk_phase;
    frame_found_next         = frame_found;
    walk_failed_next         = walk_failed;
    frame_height_next        = frame_height;
    frame_width_next         = frame_width;
    if (saturated) begin
      if (!frame_found) begin
        walk_failed_next = 1'b1;
      end
    end else if (!walk_failed) begin
      case (walk_phase)
        PH_MARK: begin
          if (byte_offset == segment_start) begin
            if (stage_byte != MARK_PREFIX) begin
              walk_failed_next = 1'b1;
            end else begin
              walk_phase_next = PH_CODE;
            end
          end
        end
        PH_CODE: begin
          if (is_sof(stage_byte)) begin
            frame_found_next = 1'b1;
            walk_phase_next  = PH_FRAME;
          end else begin
            walk_phase_next = PH_LENH;
          end
        end
        PH_LENH: begin
          segment_length_high_next = stage_byte;
          walk_phase_next          = PH_LENL;
        end
        PH_LENL: begin
          if (seg_length < 16'd2) begin
            walk_failed_next = 1'b1;
          end else begin
            segment_start_next = seg_sum[SUM_W-1] ? OFF_MAX : seg_sum[OFFSET_BITS-1:0];
            walk_phase_next    = PH_MARK;
          end
        end
        PH_FRAME: begin
          if (seg_dist == SUM_W'(5)) begin
            frame_height_next = {stage_byte, frame_height[7:0]};
          end else if (seg_dist == SUM_W'(6)) begin
            frame_height_next = {frame_height[15:8], stage_byte};
          end else if (seg_dist == SUM_W'(7)) begin
            frame_width_next = {stage_byte, frame_width[7:0]};
          end else if (seg_dist == SUM_W'(8)) begin
            frame_width_next = {frame_width[15:8], stage_byte};
            walk_phase_next  = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Header bytes as they stand after this beat, with the current byte forwarded.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (hdr_write && (byte_offset[HDR_IDX_W-1:0] == HDR_IDX_W'(i))) begin
        hv[i] = stage_byte;
      end else begin
        hv[i] = header_store[i];
      end
    end
  end

  // Format recognition and dimension selection at the last byte.
  always_comb begin
    long_enough = saturated || (byte_offset >= OFFSET_BITS'(HEADER_BYTES - 1));
    // The segment start is stable once the walk is done, so the file length after
    // this beat is the current offset plus the increment.
    if (saturated) begin
      frame_fits = !seg_dist[SUM_W-1] && (seg_dist[OFFSET_BITS-1:0] >= OFFSET_BITS'(12));
    end else begin
      frame_fits = !seg_dist[SUM_W-1] && (seg_dist[OFFSET_BITS-1:0] >= OFFSET_BITS'(11));
    end
    soi_ok  = (hv[0] == MARK_PREFIX) && (hv[1] == SOI_CODE) && (hv[2] == MARK_PREFIX);
    jfif_ok = soi_ok && (hv[3] == APP0_CODE) && (hv[6] == "J") && (hv[7] == "F") &&
              (hv[8] == "I") && (hv[9] == "F");
    gif_ok  = (hv[0] == "G") && (hv[1] == "I") && (hv[2] == "F");
    png_ok  = (hv[0] == PNG_LEAD) && (hv[1] == "P") && (hv[2] == "N") && (hv[3] == "G") &&
              (hv[4] == PNG_CR) && (hv[5] == PNG_LF) && (hv[6] == PNG_EOF) &&
              (hv[7] == PNG_LF) && (hv[12] == "I") && (hv[13] == "H") &&
              (hv[14] == "D") && (hv[15] == "R");

    res_found  = 1'b0;
    res_format = FMT_NONE;
    res_width  = 32'd0;
    res_height = 32'd0;
    if (long_enough) begin
      if (soi_ok) begin
        if (jfif_ok && frame_found_next && !walk_failed_next &&
            (walk_phase_next == PH_DONE) && frame_fits) begin
          res_found  = 1'b1;
          res_format = FMT_JPEG;
          res_width  = {16'd0, frame_width_next};
          res_height = {16'd0, frame_height_next};
        end
      end else if (gif_ok) begin
        res_found  = 1'b1;
        res_format = FMT_GIF;
        res_width  = {16'd0, hv[7], hv[6]};
        res_height = {16'd0, hv[9], hv[8]};
      end else if (png_ok) begin
        res_found  = 1'b1;
        res_format = FMT_PNG;
        res_width  = {hv[16], hv[17], hv[18], hv[19]};
        res_height = {hv[20], hv[21], hv[22], hv[23]};
      end
    end
  end

  // Walk state: back to reset values after every last beat.
  always_ff @(posedge clk) begin
    if (rst || (advance && stage_last)) begin
      byte_offset         <= '0;
      segment_start       <= SEG_INIT;
      segment_length_high <= 8'd0;
      walk_phase          <= PH_MARK;
      frame_found         <= 1'b0;
      walk_failed         <= 1'b0;
      frame_height        <= 16'd0;
      frame_width         <= 16'd0;
    end else if (advance) begin
      byte_offset         <= byte_offset_next;
      segment_start       <= segment_start_next;
      segment_length_high <= segment_length_high_next;
      walk_phase          <= walk_phase_next;
      frame_found         <= frame_found_next;
      walk_failed         <= walk_failed_next;
      frame_height        <= frame_height_next;
      frame_width         <= frame_width_next;
    end
  end

  // Header store capture of the leading file bytes.
  always_ff @(posedge clk) begin
    if (advance && hdr_write) begin
      header_store[byte_offset[HDR_IDX_W-1:0]] <= stage_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && stage_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_last) begin
      result.found        <= res_found;
      result.image_format <= res_format;
      result.image_width  <= res_width;
      result.image_height <= res_height;
    end
  end

  // A new result appears only after a last beat left the byte register.
  `IHSP_ASSERT(a_result_from_last, $rose(result.valid) |-> $past(stage_valid && stage_last), "result without a last beat")
  // The walk reaches its end only through a start-of-frame segment.
  `IHSP_ASSERT(a_done_has_frame, (walk_phase == PH_DONE) |-> frame_found, "walk done without a frame")
  // The byte register stalls only for a last beat that waits on the result register.
  `IHSP_ASSERT_NEVER(a_stall_only_last, !stream.ready && !(stage_valid && stage_last), "stall without a waiting last beat")

endmodule
